### rtl/owts_pkg.sv
// Package for the one-wire temperature read sequencer: bus phase codes,
// configuration register indexes, reset values and the command byte table.
// No dependencies.
`default_nettype none

package owts_pkg;

  localparam int unsigned NumCfg   = 7;
  localparam int unsigned CfgWidth = 16;

  // One-wire ROM and function commands
  localparam logic [7:0] CmdSkipRom   = 8'hCC;
  localparam logic [7:0] CmdConvert   = 8'h44;
  localparam logic [7:0] CmdReadPad   = 8'hBE;
  localparam logic [7:0] CmdNone      = 8'h00;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhRstRel   = 4'd1,
    PhRstLow   = 4'd2,
    PhPresWait = 4'd3,
    PhPresTail = 4'd4,
    PhWrLow    = 4'd5,
    PhWrHold   = 4'd6,
    PhWrRec    = 4'd7,
    PhRdLow    = 4'd8,
    PhRdWait   = 4'd9,
    PhRdTail   = 4'd10,
    PhFinish   = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    CfgRstRel   = 3'd0,
    CfgRstLow   = 3'd1,
    CfgPresWait = 3'd2,
    CfgPresTail = 3'd3,
    CfgWrHold   = 3'd4,
    CfgRdSample = 3'd5,
    CfgRdTail   = 3'd6
  } cfg_idx_e;

  // Step numbers within one read sequence
  localparam logic [2:0] StepFirstRst   = 3'd0;
  localparam logic [2:0] StepSkipFirst  = 3'd1;
  localparam logic [2:0] StepConvert    = 3'd2;
  localparam logic [2:0] StepSecondRst  = 3'd3;
  localparam logic [2:0] StepSkipSecond = 3'd4;
  localparam logic [2:0] StepReadCmd    = 3'd5;
  localparam logic [2:0] StepRdLowByte  = 3'd6;
  localparam logic [2:0] StepRdHiByte   = 3'd7;

  typedef logic [CfgWidth-1:0] cfg_word_t;

  localparam cfg_word_t CfgDefaults [NumCfg] = '{
    16'd8, 16'd80, 16'd14, 16'd20, 16'd5, 16'd2, 16'd30
  };

  function automatic logic [7:0] step_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      StepSkipFirst, StepSkipSecond: cmd = CmdSkipRom;
      StepConvert:                   cmd = CmdConvert;
      StepReadCmd:                   cmd = CmdReadPad;
      default:                       cmd = CmdNone;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

### rtl/onewire_temperature_read_sequencer_core.sv
// One-wire bus master: reset/presence, skip-ROM + convert, reset, skip-ROM +
// read scratchpad, then two bytes read LSB first. Uses owts_pkg.
`default_nettype none

// Channel  | Direction | Handshake               | Word
// ---------+-----------+-------------------------+------------------------------
// in       | input     | in_valid_i / in_stall_o | start_req_i, line_in_i
// out      | output    | out_valid_o/out_stall_i | line_release_o, busy_res_o,
//          |           |                         | done_res_o, read_ok_o, temp_raw_o
// cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Each accepted input word is one bus tick and yields one output word in the
// next cycle; a word can be accepted every cycle while in_stall_o is low.
// The sequencer state and the output register are the only pipeline stage.
// in_stall_o rises only while the output register is full and stalled.
// Reset loads the default tick counts and puts the sequencer idle.
module onewire_temperature_read_sequencer_core
  import owts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_req_i,
  input  wire logic        line_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             line_release_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             read_ok_o,
  output logic [15:0]      temp_raw_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_word_t   cfg_q [NumCfg];
  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  step_q, step_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] temp_q, temp_d;
  logic        ok_q, ok_d;

  logic        out_valid_q;
  logic        rel_q, busy_q, done_q, rdok_q;
  logic [15:0] traw_q;

  logic        in_acc, out_acc;
  logic        rel_c, busy_c, done_c;
  cfg_word_t   lim_sel;
  logic [16:0] lim_eff;
  logic        reached;
  logic        begin_en;
  logic [2:0]  begin_s;

  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCfg; k++) cfg_q[k] <= CfgDefaults[k];
    end else if (cfg_we_i && ({1'b0, cfg_index_i} < 4'(NumCfg))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Tick limit for the current phase; zero counts as one tick
  always_comb begin
    case (phase_q)
      PhRstRel:   lim_sel = cfg_q[CfgRstRel];
      PhRstLow:   lim_sel = cfg_q[CfgRstLow];
      PhPresWait: lim_sel = cfg_q[CfgPresWait];
      PhPresTail: lim_sel = cfg_q[CfgPresTail];
      PhWrHold:   lim_sel = cfg_q[CfgWrHold];
      PhRdWait:   lim_sel = cfg_q[CfgRdSample];
      PhRdTail:   lim_sel = cfg_q[CfgRdTail];
      default:    lim_sel = cfg_q[CfgRstRel];
    endcase
    lim_eff = (lim_sel == '0) ? 17'd1 : {1'b0, lim_sel};
    reached = ({1'b0, tick_q} + 17'd1) >= lim_eff;
  end

  // Word fields reflect the state at the start of the tick
  always_comb begin
    case (phase_q)
      PhRstLow, PhWrLow, PhRdLow: rel_c = 1'b0;
      PhWrHold:                   rel_c = shift_q[0];
      default:                    rel_c = 1'b1;
    endcase
    case (phase_q)
      PhRstRel, PhRstLow, PhPresWait, PhPresTail, PhWrLow, PhWrHold,
      PhWrRec, PhRdLow, PhRdWait, PhRdTail: busy_c = 1'b1;
      default:                              busy_c = 1'b0;
    endcase
    done_c = (phase_q == PhFinish);
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    step_d   = step_q;
    shift_d  = shift_q;
    temp_d   = temp_q;
    ok_d     = ok_q;
    begin_en = 1'b0;
    begin_s  = step_q + 3'd1;

    case (phase_q)
      PhIdle: begin
        if (start_req_i) begin
          begin_en = 1'b1;
          begin_s  = StepFirstRst;
        end
      end
      PhRstRel, PhRstLow, PhWrHold: begin
        if (reached) begin
          tick_d = '0;
          case (phase_q)
            PhRstRel: phase_d = PhRstLow;
            PhRstLow: phase_d = PhPresWait;
            default:  phase_d = PhWrRec;
          endcase
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      PhPresWait: begin
        if (reached) begin
          tick_d = '0;
          // no presence pulse on the first reset: abort
          if (step_q == StepFirstRst && line_in_i) begin
            ok_d    = 1'b0;
            phase_d = PhFinish;
          end else begin
            phase_d = PhPresTail;
          end
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      PhPresTail: begin
        if (reached) begin
          begin_en = 1'b1;
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      PhWrLow: begin
        phase_d = PhWrHold;
        tick_d  = '0;
      end
      PhWrRec: begin
        shift_d = shift_q >> 1;
        if (bit_q == 3'd7) begin
          begin_en = 1'b1;
        end else begin
          bit_d   = bit_q + 3'd1;
          phase_d = PhWrLow;
          tick_d  = '0;
        end
      end
      PhRdLow: begin
        phase_d = PhRdWait;
        tick_d  = '0;
      end
      PhRdWait: begin
        if (reached) begin
          shift_d = {line_in_i, shift_q[7:1]};
          phase_d = PhRdTail;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      PhRdTail: begin
        if (!reached) begin
          tick_d = tick_q + 16'd1;
        end else if (bit_q != 3'd7) begin
          bit_d   = bit_q + 3'd1;
          phase_d = PhRdLow;
          tick_d  = '0;
        end else if (step_q == StepRdLowByte) begin
          temp_d   = {temp_q[15:8], shift_q};
          begin_en = 1'b1;
          begin_s  = StepRdHiByte;
        end else begin
          temp_d  = {shift_q, temp_q[7:0]};
          ok_d    = 1'b1;
          phase_d = PhFinish;
          tick_d  = '0;
        end
      end
      PhFinish: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase

    // Start the next step: reset pulse, command write or byte read
    if (begin_en) begin
      step_d = begin_s;
      bit_d  = '0;
      tick_d = '0;
      if (begin_s == StepFirstRst || begin_s == StepSecondRst) begin
        phase_d = PhRstRel;
      end else if (begin_s >= StepRdLowByte) begin
        shift_d = '0;
        phase_d = PhRdLow;
      end else begin
        shift_d = step_cmd(begin_s);
        phase_d = PhWrLow;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      step_q  <= '0;
      shift_q <= '0;
      temp_q  <= '0;
      ok_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      temp_q  <= temp_d;
      ok_q    <= ok_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rel_q  <= rel_c;
      busy_q <= busy_c;
      done_q <= done_c;
      rdok_q <= ok_q;
      traw_q <= temp_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_release_o = rel_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign read_ok_o      = rdok_q;
  assign temp_raw_o     = traw_q;

  // Finish always returns to idle on the next tick
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFinish && in_acc) |=> (phase_q == PhIdle))
    else $error("finish phase did not return to idle");

  // An accepted tick always leaves a word in the output register
  a_acc_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted tick produced no output word");

  // ok flag only sets when the second byte completes
  a_ok_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ok_q) |-> (phase_q == PhFinish && $past(phase_q) == PhRdTail))
    else $error("ok flag set outside read completion");

  // Temperature only changes at the end of a byte read
  a_temp_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(temp_q) |-> ($past(phase_q) == PhRdTail && $past(in_acc)))
    else $error("temperature changed outside read tail");

endmodule

`default_nettype wire
